### rtl/aec_pkg.sv
// Shared types and constants for the audio effect chain.
// Holds the register map, the configuration record, the sequencer states
// and the fixed-point constants. Depends on nothing.
package aec_pkg;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  // Width of the unsigned-factor operand of the shared multiplier (signed).
  localparam int MUL_B_BITS = 21;

  // Unity in Q1.16 / Q4.16.
  localparam logic [16:0] Q16_ONE = 17'd65536;

  // Division by ten of the mix numerator: (v * MIX_RECIP) >> MIX_SHIFT is exact
  // for every numerator below 2^20.
  localparam logic [19:0] MIX_RECIP = 20'd838861;
  localparam int          MIX_SHIFT = 23;

  // Stage enable bit positions.
  localparam int EN_GAIN  = 0;
  localparam int EN_COMP  = 1;
  localparam int EN_MIX   = 2;
  localparam int EN_DELAY = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_STAGE_ENABLES  = 3'd0,
    REG_FLAT_GAIN      = 3'd1,
    REG_COMP_THRESHOLD = 3'd2,
    REG_COMP_SLOPE     = 3'd3,
    REG_COMP_OUT_GAIN  = 3'd4,
    REG_MIX_WET        = 3'd5,
    REG_DELAY_LENGTH   = 3'd6,
    REG_DELAY_GAINS    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [3:0]  stage_enables;
    logic [19:0] flat_gain;
    logic [22:0] comp_threshold;
    logic [16:0] comp_slope;
    logic [19:0] comp_out_gain;
    logic [16:0] mix_wet;
    logic [16:0] delay_length;
    logic [31:0] delay_gains;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    stage_enables:  4'd0,
    flat_gain:      20'd65536,
    comp_threshold: 23'd838861,
    comp_slope:     17'd16384,
    comp_out_gain:  20'd65536,
    mix_wet:        17'd32768,
    delay_length:   17'd12000,
    delay_gains:    32'd1717050
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAIN_MUL,
    ST_GAIN_RND,
    ST_COMP_MUL,
    ST_COMP_ADD,
    ST_MK_MUL,
    ST_MK_RND,
    ST_MIX_DIV,
    ST_MIX_MUL,
    ST_MIX_RND,
    ST_DLY_RD,
    ST_DLY_MUL1,
    ST_DLY_MUL2,
    ST_DLY_MUL3,
    ST_DLY_WR,
    ST_OUT
  } state_t;

endpackage

### rtl/aec_if.sv
// Valid/ready channel interfaces of the audio effect chain: sample input,
// sample output and configuration write. Depends on aec_pkg.
interface aec_in_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                          block_end;
  modport source(output valid, output in_sample, output block_end, input ready);
  modport sink(input valid, input in_sample, input block_end, output ready);
endinterface

interface aec_out_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          out_block_end;
  modport source(output valid, output out_sample, output out_block_end, input ready);
  modport sink(input valid, input out_sample, input out_block_end, output ready);
endinterface

interface aec_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [aec_pkg::CFG_IDX_BITS-1:0]   index;
  logic [aec_pkg::CFG_DATA_BITS-1:0]  data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

### rtl/aec_cfg_regs.sv
// Configuration register file of the audio effect chain.
// Decodes register writes into the cfg_t record. Depends on aec_pkg.
module aec_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [aec_pkg::CFG_IDX_BITS-1:0]  wr_index,
  input  logic [aec_pkg::CFG_DATA_BITS-1:0] wr_data,
  output aec_pkg::cfg_t                     cfg
);

  aec_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= aec_pkg::CFG_RESET;
    end else if (wr_en) begin
      unique case (aec_pkg::reg_idx_t'(wr_index))
        aec_pkg::REG_STAGE_ENABLES:  cfg_r.stage_enables  <= wr_data[3:0];
        aec_pkg::REG_FLAT_GAIN:      cfg_r.flat_gain      <= wr_data[19:0];
        aec_pkg::REG_COMP_THRESHOLD: cfg_r.comp_threshold <= wr_data[22:0];
        aec_pkg::REG_COMP_SLOPE:     cfg_r.comp_slope     <= wr_data[16:0];
        aec_pkg::REG_COMP_OUT_GAIN:  cfg_r.comp_out_gain  <= wr_data[19:0];
        aec_pkg::REG_MIX_WET:        cfg_r.mix_wet        <= wr_data[16:0];
        aec_pkg::REG_DELAY_LENGTH:   cfg_r.delay_length   <= wr_data[16:0];
        aec_pkg::REG_DELAY_GAINS:    cfg_r.delay_gains    <= wr_data;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/aec_delay_mem.sv
// Delay line storage: one write port and one read port with registered
// read data. No dependencies.
module aec_delay_mem #(
  parameter int DEPTH = 131072,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/audio_effect_chain_unit.sv
// Top level of the audio effect chain: sequencer, shared multiplier datapath
// and output register. Depends on aec_pkg, aec_if, aec_cfg_regs, aec_delay_mem.
//
// Each transfer on in_ch carries one signed Q1.23 sample (SAMPLE_BITS wide).
// The sample runs through the enabled stages in order (flat gain, hard-knee
// compressor with makeup gain, mix attenuation 1 - 0.7*wet, feedback delay)
// and is then clamped to +/-0.967 of full scale; one result is transferred on
// out_ch for every input, in order, with block_end passed along unchanged.
// One item is processed at a time and all arithmetic is stepped through a
// single shared multiplier with a register after it, so an item steps from
// IDLE through the enabled stages to OUT and disabled stages are skipped:
// gain (multiply, round), compressor (multiply, knee add, makeup multiply,
// round), mix (divide, multiply, round) and delay (read of the delay memory,
// dry, wet and feedback multiplies, write back). The output register lets the
// next sample be taken while a result still waits on out_ch. The delay memory
// needs no clearing pass after reset: a wrap flag and the write pointer tell
// whether the entry being read has been written since reset, and an entry not
// yet written reads as zero. Configuration is written through cfg_ch, which is
// always ready; registers should only be written while the block is idle.
module audio_effect_chain_unit #(
  parameter int DELAY_DEPTH = 131072,
  parameter int SAMPLE_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  aec_in_if.sink      in_ch,
  aec_out_if.source   out_ch,
  aec_cfg_if.sink     cfg_ch
);

  localparam int SB   = SAMPLE_BITS;
  localparam int AW   = (SB + 1 > 20) ? SB + 1 : 20;
  localparam int BW   = aec_pkg::MUL_B_BITS;
  localparam int PW   = AW + BW;
  localparam int EW   = PW + 2;
  localparam int PTRW = $clog2(DELAY_DEPTH);

  localparam longint unsigned CEIL_L =
    ((64'd967 << (SAMPLE_BITS - 1)) + 64'd500) / 64'd1000;
  localparam logic signed [SB-1:0] CEIL_S = SB'(CEIL_L);

  localparam logic signed [EW-1:0] SMAX_E = EW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [EW-1:0] SMIN_E = -SMAX_E - EW'(1);

  // Round a Q.16 product to nearest, ties away from zero.
  function automatic logic signed [EW-1:0] rnd16(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] bias;
    bias = v[EW-1] ? EW'(32767) : EW'(32768);
    return (v + bias) >>> 16;
  endfunction

  function automatic logic signed [SB-1:0] sat_s(input logic signed [EW-1:0] v);
    logic signed [SB-1:0] res;
    if (v > SMAX_E) begin
      res = {1'b0, {(SB-1){1'b1}}};
    end else if (v < SMIN_E) begin
      res = {1'b1, {(SB-1){1'b0}}};
    end else begin
      res = v[SB-1:0];
    end
    return res;
  endfunction

  // Configuration.
  aec_pkg::cfg_t cfg;

  assign cfg_ch.ready = 1'b1;

  aec_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  // Control state.
  aec_pkg::state_t   state_r, state_nxt;
  logic [PTRW-1:0]   wp_r;
  logic              wrapped_r;
  logic              out_valid_r;

  // Datapath registers.
  logic signed [SB-1:0] x_r;
  logic                 be_r;
  logic signed [PW-1:0] prod_r;
  logic signed [EW-1:0] acc_r;
  logic signed [SB-1:0] d_r;
  logic                 cmp_r;
  logic                 neg_r;
  logic                 rd_ok_r;
  logic signed [SB-1:0] out_sample_r;
  logic                 out_be_r;

  // Sequencer outputs.
  logic                 in_ready;
  logic                 mem_rd_en;
  logic                 mem_wr_en;
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod_nxt;

  logic in_xfer;
  logic out_free;

  assign in_xfer  = in_ch.valid && in_ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Stage arithmetic around the shared multiplier.
  logic signed [EW-1:0] xe;
  logic signed [EW-1:0] prod_e;
  logic signed [EW-1:0] mag_e;
  logic signed [EW-1:0] thr_e;
  logic signed [EW-1:0] diff_e;
  logic signed [EW-1:0] comp_c;
  logic                 over;
  logic [16:0]          mix_w;
  logic [19:0]          mix_num;
  logic [16:0]          mix_q;
  logic [16:0]          mix_g;
  logic [15:0]          dly_wet;
  logic [15:0]          dly_fb;
  logic [16:0]          dly_dry;
  logic signed [SB-1:0] store_val;
  logic signed [SB-1:0] clamp_val;

  assign xe      = EW'(x_r);
  assign prod_e  = EW'(prod_r);
  assign mag_e   = x_r[SB-1] ? -xe : xe;
  assign thr_e   = EW'(cfg.comp_threshold);
  assign over    = mag_e > thr_e;
  assign diff_e  = mag_e - thr_e;
  assign comp_c  = thr_e + rnd16(prod_e);

  assign mix_w   = (cfg.mix_wet > aec_pkg::Q16_ONE) ? aec_pkg::Q16_ONE : cfg.mix_wet;
  assign mix_num = 20'(mix_w) * 20'd7 + 20'd5;
  assign mix_q   = prod_r[aec_pkg::MIX_SHIFT +: 17];
  assign mix_g   = aec_pkg::Q16_ONE - mix_q;

  assign dly_wet = cfg.delay_gains[15:0];
  assign dly_fb  = cfg.delay_gains[31:16];
  assign dly_dry = aec_pkg::Q16_ONE - {1'b0, dly_wet};

  // Value written back to the delay line: input plus feedback of the tap.
  assign store_val = sat_s(xe + rnd16(prod_e));

  assign clamp_val = (x_r > CEIL_S)  ? CEIL_S :
                     (x_r < -CEIL_S) ? -CEIL_S : x_r;

  assign prod_nxt = PW'(mul_a) * PW'(mul_b);

  // Delay tap address. Lengths beyond the line are held to its last entry.
  logic [PTRW-1:0] len_eff;
  logic [PTRW-1:0] rd_addr;
  logic            rd_ok;

  assign len_eff = (32'(cfg.delay_length) >= 32'(DELAY_DEPTH)) ?
                   PTRW'(DELAY_DEPTH - 1) : PTRW'(cfg.delay_length);
  assign rd_addr = (wp_r >= len_eff) ? (wp_r - len_eff) :
                   PTRW'((PTRW+1)'(wp_r) + (PTRW+1)'(DELAY_DEPTH) - (PTRW+1)'(len_eff));
  // Before the first wrap only entries below the write pointer hold data.
  assign rd_ok   = wrapped_r || ((len_eff != '0) && (len_eff <= wp_r));

  logic [SB-1:0] mem_rd_data;

  aec_delay_mem #(
    .DEPTH (DELAY_DEPTH),
    .WIDTH (SB)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (wp_r),
    .wr_data (store_val),
    .rd_en   (mem_rd_en),
    .rd_addr (rd_addr),
    .rd_data (mem_rd_data)
  );

  // Next stage after each stage, skipping the disabled ones.
  aec_pkg::state_t nx_gain, nx_comp, nx_mix, nx_dly;

  assign nx_dly  = cfg.stage_enables[aec_pkg::EN_DELAY] ? aec_pkg::ST_DLY_RD : aec_pkg::ST_OUT;
  assign nx_mix  = cfg.stage_enables[aec_pkg::EN_MIX]   ? aec_pkg::ST_MIX_DIV : nx_dly;
  assign nx_comp = cfg.stage_enables[aec_pkg::EN_COMP]  ? aec_pkg::ST_COMP_MUL : nx_mix;
  assign nx_gain = cfg.stage_enables[aec_pkg::EN_GAIN]  ? aec_pkg::ST_GAIN_MUL : nx_comp;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aec_pkg::ST_IDLE:     if (in_ch.valid) state_nxt = nx_gain;
      aec_pkg::ST_GAIN_MUL: state_nxt = aec_pkg::ST_GAIN_RND;
      aec_pkg::ST_GAIN_RND: state_nxt = nx_comp;
      aec_pkg::ST_COMP_MUL: state_nxt = aec_pkg::ST_COMP_ADD;
      aec_pkg::ST_COMP_ADD: state_nxt = aec_pkg::ST_MK_MUL;
      aec_pkg::ST_MK_MUL:   state_nxt = aec_pkg::ST_MK_RND;
      aec_pkg::ST_MK_RND:   state_nxt = nx_mix;
      aec_pkg::ST_MIX_DIV:  state_nxt = aec_pkg::ST_MIX_MUL;
      aec_pkg::ST_MIX_MUL:  state_nxt = aec_pkg::ST_MIX_RND;
      aec_pkg::ST_MIX_RND:  state_nxt = nx_dly;
      aec_pkg::ST_DLY_RD:   state_nxt = aec_pkg::ST_DLY_MUL1;
      aec_pkg::ST_DLY_MUL1: state_nxt = aec_pkg::ST_DLY_MUL2;
      aec_pkg::ST_DLY_MUL2: state_nxt = aec_pkg::ST_DLY_MUL3;
      aec_pkg::ST_DLY_MUL3: state_nxt = aec_pkg::ST_DLY_WR;
      aec_pkg::ST_DLY_WR:   state_nxt = aec_pkg::ST_OUT;
      aec_pkg::ST_OUT:      if (out_free) state_nxt = aec_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, memory strobes and multiplier operands.
  always_comb begin
    in_ready  = 1'b0;
    mem_rd_en = 1'b0;
    mem_wr_en = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      aec_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      aec_pkg::ST_GAIN_MUL: begin
        mul_a = AW'(x_r);
        mul_b = BW'(cfg.flat_gain);
      end
      aec_pkg::ST_COMP_MUL: begin
        mul_a = AW'(diff_e);
        mul_b = BW'(cfg.comp_slope);
      end
      aec_pkg::ST_MK_MUL: begin
        mul_a = AW'(x_r);
        mul_b = BW'(cfg.comp_out_gain);
      end
      aec_pkg::ST_MIX_DIV: begin
        mul_a = AW'(mix_num);
        mul_b = BW'(aec_pkg::MIX_RECIP);
      end
      aec_pkg::ST_MIX_MUL: begin
        mul_a = AW'(x_r);
        mul_b = BW'(mix_g);
      end
      aec_pkg::ST_DLY_RD: begin
        mem_rd_en = 1'b1;
      end
      aec_pkg::ST_DLY_MUL1: begin
        mul_a = AW'(x_r);
        mul_b = BW'(dly_dry);
      end
      aec_pkg::ST_DLY_MUL2: begin
        mul_a = AW'(d_r);
        mul_b = BW'(dly_wet);
      end
      aec_pkg::ST_DLY_MUL3: begin
        mul_a = AW'(d_r);
        mul_b = BW'(dly_fb);
      end
      aec_pkg::ST_DLY_WR: begin
        mem_wr_en = 1'b1;
      end
      aec_pkg::ST_GAIN_RND, aec_pkg::ST_COMP_ADD, aec_pkg::ST_MK_RND,
      aec_pkg::ST_MIX_RND, aec_pkg::ST_OUT: begin
      end
    endcase
  end

  assign in_ch.ready = in_ready;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aec_pkg::ST_IDLE;
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mem_wr_en) begin
        if (wp_r == PTRW'(DELAY_DEPTH - 1)) begin
          wp_r      <= '0;
          wrapped_r <= 1'b1;
        end else begin
          wp_r <= wp_r + PTRW'(1);
        end
      end
      if (state_r == aec_pkg::ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers. The product register is consumed the cycle after
  // each multiply, so it is simply reloaded every cycle.
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    unique case (state_r)
      aec_pkg::ST_IDLE: begin
        if (in_xfer) begin
          x_r  <= in_ch.in_sample;
          be_r <= in_ch.block_end;
        end
      end
      aec_pkg::ST_GAIN_RND, aec_pkg::ST_MK_RND, aec_pkg::ST_MIX_RND: begin
        x_r <= sat_s(rnd16(prod_e));
      end
      aec_pkg::ST_COMP_MUL: begin
        cmp_r <= over;
        neg_r <= x_r[SB-1];
      end
      aec_pkg::ST_COMP_ADD: begin
        if (cmp_r) begin
          x_r <= sat_s(neg_r ? -comp_c : comp_c);
        end
      end
      aec_pkg::ST_DLY_RD: begin
        rd_ok_r <= rd_ok;
      end
      aec_pkg::ST_DLY_MUL1: begin
        d_r <= rd_ok_r ? mem_rd_data : '0;
      end
      aec_pkg::ST_DLY_MUL2: begin
        acc_r <= prod_e;
      end
      aec_pkg::ST_DLY_MUL3: begin
        acc_r <= acc_r + prod_e;
      end
      aec_pkg::ST_DLY_WR: begin
        x_r <= sat_s(rnd16(acc_r));
      end
      aec_pkg::ST_OUT: begin
        if (out_free) begin
          out_sample_r <= clamp_val;
          out_be_r     <= be_r;
        end
      end
      aec_pkg::ST_GAIN_MUL, aec_pkg::ST_MK_MUL, aec_pkg::ST_MIX_DIV,
      aec_pkg::ST_MIX_MUL: begin
      end
    endcase
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_sample    = out_sample_r;
  assign out_ch.out_block_end = out_be_r;

endmodule
